// ----- rtl/sm3_pkg.sv -----
// sm3 package: constants, types and round functions shared by the sm3 engine
// no dependencies
package sm3_pkg;
    localparam int BLOCK_BYTES = 64;
    localparam int FIFO_DEPTH = 4;
    localparam logic [31:0] T_LO = 32'h79cc4519;
    localparam logic [31:0] T_HI = 32'h7a879d8a;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [255:0] IV = {32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
                                   32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e};

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       last;
    } sm3_item_t;

    typedef struct packed {
        logic         start;
        logic [511:0] block;
        logic [255:0] cv;
    } sm3_job_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] p0(input logic [31:0] x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] p1(input logic [31:0] x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction
endpackage

// ----- rtl/sm3_hash_engine_top.sv -----
// sm3 hash engine top level: byte stream in, 256-bit digest out
// a full block holds the back end until the core is done; the digest is valid once
// the padding block, and an extra length block if the length does not fit, are compressed
// one byte per cycle into the queue while it has room; the back end takes no bytes
// while the one-round-per-cycle core runs
// reset: synchronous active-low aresetn restores the iv and empties the queue
// depends on sm3_pkg, sm3_front, sm3_back
module sm3_hash_engine_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte
    input  logic         s_tuser,   // byte_present
    input  logic         s_tlast,   // message_end
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [255:0] m_tdata    // digest_word_0 .. digest_word_7
);
    import sm3_pkg::*;

    sm3_item_t in_item, q_item;
    logic q_valid, q_ready;
    logic [255:0] dig;

    assign in_item = '{data: s_tdata, present: s_tuser, last: s_tlast};

    sm3_front u_front (.aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid),
        .in_ready(s_tready), .in_item(in_item), .out_valid(q_valid),
        .out_ready(q_ready), .out_item(q_item));

    sm3_back u_back (.aclk(aclk), .aresetn(aresetn), .in_valid(q_valid),
        .in_ready(q_ready), .in_item(q_item), .out_valid(m_tvalid),
        .out_ready(m_tready), .out_digest(dig));

    always_comb begin
        for (int k = 0; k < 8; k++) m_tdata[32*k +: 32] = dig[255-32*k -: 32];
    end
endmodule

// ----- rtl/sm3_front.sv -----
// sm3 front end: item fifo between the stream slave and the block builder
// depends on sm3_pkg
module sm3_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  sm3_pkg::sm3_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output sm3_pkg::sm3_item_t  out_item
);
    import sm3_pkg::*;
    localparam int AW = $clog2(FIFO_DEPTH);

    sm3_item_t mem [FIFO_DEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   cnt_reg;
    logic push, pop;

    assign in_ready  = cnt_reg != (AW+1)'(FIFO_DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_item  = mem[rd_reg];
    assign push = in_valid && in_ready && (in_item.present || in_item.last);
    assign pop  = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) mem[wr_reg] <= in_item;
        if (!aresetn) begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop) rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule

// ----- rtl/sm3_compress.sv -----
// sm3 compression core: 16-word expansion window, one round per cycle
// depends on sm3_pkg
module sm3_compress (
    input  logic              aclk,
    input  logic              aresetn,
    input  sm3_pkg::sm3_job_t job,
    output logic              busy,
    output logic              done,
    output logic [255:0]      cv_out
);
    import sm3_pkg::*;

    logic [511:0] w_reg, w_next;
    logic [31:0]  r_reg [8];
    logic [255:0] cv_reg;
    logic [6:0]   idx_reg;
    logic         busy_reg, done_reg;
    logic [31:0]  wj, wj4, tj, a12, ss1, ss2, ff, gg, tt1, tt2, wn;
    logic [31:0]  w [16];

    always_comb begin
        for (int k = 0; k < 16; k++) w[k] = w_reg[511-32*k -: 32];
        wj  = w[0];
        wj4 = w[4];
        wn  = p1(w[0] ^ w[7] ^ rotl(w[13], 5'd15)) ^ rotl(w[3], 5'd7) ^ w[10];
        w_next = {w_reg[479:0], wn};
        tj  = (idx_reg < 7'd16) ? T_LO : T_HI;
        a12 = rotl(r_reg[0], 5'd12);
        ss1 = rotl(a12 + r_reg[4] + rotl(tj, idx_reg[4:0]), 5'd7);
        ss2 = ss1 ^ a12;
        if (idx_reg < 7'd16) begin
            ff = r_reg[0] ^ r_reg[1] ^ r_reg[2];
            gg = r_reg[4] ^ r_reg[5] ^ r_reg[6];
        end else begin
            ff = (r_reg[0] & r_reg[1]) | (r_reg[0] & r_reg[2]) | (r_reg[1] & r_reg[2]);
            gg = (r_reg[4] & r_reg[5]) | (~r_reg[4] & r_reg[6]);
        end
        tt1 = ff + r_reg[3] + ss2 + (wj ^ wj4);
        tt2 = gg + r_reg[7] + ss1 + wj;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    always_comb begin
        for (int k = 0; k < 8; k++)
            cv_out[255-32*k -: 32] = cv_reg[255-32*k -: 32];
    end

    always_ff @(posedge aclk) begin
        if (job.start && !busy_reg) begin
            w_reg <= job.block;
            cv_reg <= job.cv;
            for (int k = 0; k < 8; k++) r_reg[k] <= job.cv[255-32*k -: 32];
        end else if (busy_reg) begin
            w_reg <= w_next;
            r_reg[3] <= r_reg[2];
            r_reg[2] <= rotl(r_reg[1], 5'd9);
            r_reg[1] <= r_reg[0];
            r_reg[0] <= tt1;
            r_reg[7] <= r_reg[6];
            r_reg[6] <= rotl(r_reg[5], 5'd19);
            r_reg[5] <= r_reg[4];
            r_reg[4] <= p0(tt2);
            if (idx_reg == 7'd63) begin
                cv_reg <= cv_reg ^ {tt1, r_reg[0], rotl(r_reg[1], 5'd9), r_reg[2],
                                    p0(tt2), r_reg[4], rotl(r_reg[5], 5'd19), r_reg[6]};
            end
        end
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            idx_reg <= '0;
        end else begin
            done_reg <= busy_reg && idx_reg == 7'd63;
            if (job.start && !busy_reg) begin
                busy_reg <= 1'b1;
                idx_reg <= '0;
            end else if (busy_reg) begin
                idx_reg <= idx_reg + 1'b1;
                if (idx_reg == 7'd63) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end
endmodule

// ----- rtl/sm3_back.sv -----
// sm3 back end: block buffer, padding sequencer and digest output register
// depends on sm3_pkg, sm3_compress
module sm3_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  sm3_pkg::sm3_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [255:0]       out_digest
);
    import sm3_pkg::*;

    localparam logic [2:0] S_FILL = 3'd0, S_WAIT = 3'd1, S_PAD = 3'd2,
                           S_PWAIT = 3'd3, S_OUT = 3'd4;

    logic [2:0]   st_reg;
    logic [511:0] buf_reg;
    logic [5:0]   fill_reg;
    logic [60:0]  cnt_reg;
    logic [255:0] cv_reg, dig_reg;
    logic         ov_reg, pend_last_reg, extra_reg;
    sm3_job_t     job;
    logic         busy, done;
    logic [255:0] cv_new;
    logic [511:0] buf_b, pad_blk;
    logic [5:0]   pos;

    sm3_compress u_core (.aclk(aclk), .aresetn(aresetn), .job(job),
                         .busy(busy), .done(done), .cv_out(cv_new));

    assign in_ready   = st_reg == S_FILL && !ov_reg;
    assign out_valid  = ov_reg;
    assign out_digest = dig_reg;

    always_comb begin
        buf_b = buf_reg;
        pos = fill_reg;
        if (in_item.present) buf_b[511-8*pos -: 8] = in_item.data;
        pad_blk = buf_reg;
        for (int k = 0; k < 64; k++)
            if (k >= int'(fill_reg)) pad_blk[511-8*k -: 8] = 8'h00;
        if (!extra_reg) pad_blk[511-8*fill_reg -: 8] = PAD_BYTE;
        if (extra_reg || fill_reg < 6'd56) pad_blk[63:0] = {cnt_reg, 3'b000};
    end

    always_ff @(posedge aclk) begin
        if (st_reg == S_FILL && in_valid && in_ready) buf_reg <= buf_b;
        if (!aresetn) begin
            st_reg <= S_FILL;
            fill_reg <= '0;
            cnt_reg <= '0;
            cv_reg <= IV;
            ov_reg <= 1'b0;
            pend_last_reg <= 1'b0;
            extra_reg <= 1'b0;
            job.start <= 1'b0;
        end else begin
            job.start <= (st_reg == S_FILL && in_valid && in_ready && in_item.present
                          && fill_reg == 6'd63) || (st_reg == S_PAD && !busy && !job.start);
            if (ov_reg && out_ready) ov_reg <= 1'b0;
            unique case (st_reg)
                S_FILL: if (in_valid && in_ready) begin
                    if (in_item.present) begin
                        fill_reg <= fill_reg + 1'b1;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    pend_last_reg <= in_item.last;
                    if (in_item.present && fill_reg == 6'd63) begin
                        job.block <= buf_b;
                        job.cv <= cv_reg;
                        st_reg <= S_WAIT;
                    end else if (in_item.last) begin
                        st_reg <= S_PAD;
                        extra_reg <= 1'b0;
                    end
                end
                S_WAIT: if (done) begin
                    cv_reg <= cv_new;
                    fill_reg <= '0;
                    if (pend_last_reg) begin
                        st_reg <= S_PAD;
                        extra_reg <= 1'b0;
                    end else st_reg <= S_FILL;
                end
                S_PAD: if (!busy && !job.start) begin
                    job.block <= pad_blk;
                    job.cv <= cv_reg;
                    st_reg <= S_PWAIT;
                end
                S_PWAIT: if (done) begin
                    if (!extra_reg && fill_reg >= 6'd56) begin
                        cv_reg <= cv_new;
                        extra_reg <= 1'b1;
                        fill_reg <= '0;
                        st_reg <= S_PAD;
                    end else begin
                        dig_reg <= cv_new;
                        st_reg <= S_OUT;
                    end
                end
                S_OUT: if (!ov_reg) begin
                    ov_reg <= 1'b1;
                    cv_reg <= IV;
                    fill_reg <= '0;
                    cnt_reg <= '0;
                    extra_reg <= 1'b0;
                    st_reg <= S_FILL;
                end
                default: st_reg <= S_FILL;
            endcase
        end
    end
endmodule

// ----- rtl/sm3_hash_engine_checker.sv -----
// port checker for the sm3 engine, bound to the top level
// depends on sm3_hash_engine_top
module sm3_hash_engine_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [255:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("valid after reset");
    a_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready |=> !m_tvalid) else $error("back to back digests");
    a_rdy: assert property (@(posedge aclk) !aresetn |=> s_tready || !aresetn)
        else $error("not ready after reset");
endmodule

bind sm3_hash_engine_top sm3_hash_engine_checker u_chk (.aclk(aclk), .aresetn(aresetn),
    .s_tready(s_tready), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tdata(m_tdata));
